// ===== hdl/ptd_pkg.sv =====
// shared types, constants and alphabet lookup for the packed five-bit text decoder
package ptd_pkg;

    localparam int CODE_W      = 5;
    localparam int NUM_CODES   = 3;
    localparam int CHAR_W      = 7;
    localparam int POS_W       = 8;
    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CODE_W-1:0] TOGGLE_CODE = 5'd31;
    localparam logic [CODE_W-1:0] LAST_INDEX  = 5'd30;

    typedef logic [1:0] slot_t;
    localparam slot_t SLOT_LAST_CODE = 2'd2;
    localparam slot_t SLOT_TERM      = 2'd3;

    // both alphabets, first character in the top byte
    localparam logic [31*8-1:0] ALPHA0_TXT = " abcdefghijklmnopqrstuvwxyz?:'-";
    localparam logic [31*8-1:0] ALPHA1_TXT = " 0123456789abcdefghilmnorstuwy-";

    typedef struct packed {
        logic [NUM_CODES-1:0][CODE_W-1:0] code;
        logic [NUM_CODES-1:0]             toggle;
        logic                             last;
    } ptd_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic [POS_W-1:0]  char_position;
        logic              end_of_string;
    } ptd_result_t;

    function automatic logic [CHAR_W-1:0] ptd_lookup(input logic sel,
                                                     input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] idx;
        logic [7:0]        base;
        logic [CHAR_W-1:0] ch;
        idx  = LAST_INDEX - code;
        base = {idx, 3'b000};
        if (code == TOGGLE_CODE)
        begin
            ch = '0;
        end
        else if (sel)
        begin
            ch = ALPHA1_TXT[base +: CHAR_W];
        end
        else
        begin
            ch = ALPHA0_TXT[base +: CHAR_W];
        end
        return ch;
    endfunction

endpackage

// ===== hdl/ptd_front.sv =====
// front stage: takes a packed word, splits it into codes and flags toggles
module ptd_front
    import ptd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] low_byte,
    input  logic [BYTE_W-1:0] high_byte,
    input  logic              q_full,
    output logic              q_push,
    output ptd_item_t         q_item
);

    logic        valid_reg;
    logic        valid_next;
    ptd_item_t   item_reg;
    ptd_item_t   item_next;
    logic [15:0] word;
    logic        accept;

    assign word   = {high_byte, low_byte};
    assign q_push = valid_reg && !q_full;
    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_item = item_reg;

    always_comb
    begin
        item_next.code[0] = word[4:0];
        item_next.code[1] = word[9:5];
        item_next.code[2] = word[14:10];
        item_next.last    = word[15];
        for (int i = 0; i < NUM_CODES; i++)
        begin
            item_next.toggle[i] = (item_next.code[i] == TOGGLE_CODE);
        end
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

`ifndef NO_ASSERTIONS
    // held word leaves or stays, never dropped while the queue is full
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && q_full) |=> (valid_reg && $stable(item_reg)))
        else $error("front word lost while queue full");
    // a transfer in is only taken when the stage is free or draining
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!valid_reg || q_push))
        else $error("front overwrote a held word");
    // pushing to the queue only while it has room
    a_qpush: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("front pushed into full queue");
`endif

endmodule

// ===== hdl/ptd_queue.sv =====
// short queue of classified words between front and back
module ptd_queue
    import ptd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  ptd_item_t wr_item,
    output logic      full,
    input  logic      rd,
    output ptd_item_t rd_item,
    output logic      empty
);

    ptd_item_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_wr;
    logic                   do_rd;

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CNT_W'(do_wr) - QUEUE_CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");
    a_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step with count");
    a_rd: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> !empty)
        else $error("queue read while empty");
`endif

endmodule

// ===== hdl/ptd_back.sv =====
// back stage: walks the codes of each word, keeps alphabet and position, buffers results
module ptd_back
    import ptd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  ptd_item_t   q_item,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output ptd_result_t result
);

    slot_t             slot_reg;
    slot_t             slot_next;
    logic              alpha_reg;
    logic              alpha_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    ptd_result_t       buf_reg [2];
    logic              head_reg;
    logic              head_next;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic              tail;
    logic              pop_ok;
    logic              out_room;
    logic              step;
    logic              is_term;
    logic              last_slot;
    logic [CODE_W-1:0] cur_code;
    logic              cur_toggle;
    logic              emit;
    ptd_result_t       new_res;

    assign empty  = (cnt_reg == 2'd0);
    assign result = buf_reg[head_reg];
    assign pop_ok = pop && !empty;
    assign tail   = head_reg ^ cnt_reg[0];

    always_comb
    begin
        unique case (slot_reg)
            2'd0:
            begin
                cur_code   = q_item.code[0];
                cur_toggle = q_item.toggle[0];
            end
            2'd1:
            begin
                cur_code   = q_item.code[1];
                cur_toggle = q_item.toggle[1];
            end
            2'd2:
            begin
                cur_code   = q_item.code[2];
                cur_toggle = q_item.toggle[2];
            end
            default:
            begin
                cur_code   = '0;
                cur_toggle = 1'b0;
            end
        endcase

        is_term   = (slot_reg == SLOT_TERM);
        out_room  = (cnt_reg != 2'd2) || pop_ok;
        step      = !q_empty && out_room;
        emit      = step && (is_term || !cur_toggle);
        last_slot = is_term || ((slot_reg == SLOT_LAST_CODE) && !q_item.last);
        q_pop     = step && last_slot;

        if (step)
        begin
            slot_next = last_slot ? slot_t'(0) : slot_reg + 1'b1;
        end
        else
        begin
            slot_next = slot_reg;
        end

        alpha_next = alpha_reg ^ (step && !is_term && cur_toggle);

        if (emit)
        begin
            pos_next = is_term ? '0 : pos_reg + 1'b1;
        end
        else
        begin
            pos_next = pos_reg;
        end

        new_res.char_code     = is_term ? '0 : ptd_lookup(alpha_reg, cur_code);
        new_res.char_position = pos_reg;
        new_res.end_of_string = is_term;

        cnt_next  = cnt_reg + 2'(emit) - 2'(pop_ok);
        head_next = head_reg ^ pop_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            alpha_reg <= 1'b0;
            pos_reg   <= '0;
            head_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            slot_reg  <= slot_next;
            alpha_reg <= alpha_next;
            pos_reg   <= pos_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            buf_reg[tail] <= new_res;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("result buffer overflow");
    a_term_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_reg == SLOT_TERM) |-> (!q_empty && q_item.last))
        else $error("terminator slot on a word without end mark");
    a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && is_term) |=> (pos_reg == '0))
        else $error("position not cleared after terminator");
    a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (slot_reg == '0))
        else $error("slot not rewound after word done");
`endif

endmodule

// ===== hdl/packed_five_bit_text_decoder.sv =====
// top level of the packed five-bit text decoder
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | push / full          | low_byte[7:0], high_byte[7:0]
//  result   | empty / pop          | char_code[6:0], char_position[7:0],
//           |                      | end_of_string
//
// the back stage walks a word one code at a time, with one more step for an end word
// that also emits the terminator; the back stage sequencer sets the rate
// when all is idle, the first result passes the front register, queue and result buffer
// a toggle code still takes a sequencer step but produces no result
// front register and a 4-deep word queue let input keep flowing while results stall
// rst_n clears alphabet, position, queue and result buffer at once
module packed_five_bit_text_decoder
    import ptd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input side
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] low_byte,
    input  logic [BYTE_W-1:0] high_byte,
    // result side
    output logic              empty,
    input  logic              pop,
    output logic [CHAR_W-1:0] char_code,
    output logic [POS_W-1:0]  char_position,
    output logic              end_of_string
);

    // front to queue
    logic        fq_push;
    logic        fq_full;
    ptd_item_t   fq_item;
    // queue to back
    logic        qb_pop;
    logic        qb_empty;
    ptd_item_t   qb_item;
    // head of result buffer
    ptd_result_t res;

    // splits the word into three codes and the end mark
    ptd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .low_byte  (low_byte),
        .high_byte (high_byte),
        .q_full    (fq_full),
        .q_push    (fq_push),
        .q_item    (fq_item)
    );

    // decouples classification from the per-code sequencer
    ptd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (fq_push),
        .wr_item (fq_item),
        .full    (fq_full),
        .rd      (qb_pop),
        .rd_item (qb_item),
        .empty   (qb_empty)
    );

    // one code per cycle while a word is queued and the result buffer has room; alphabet and position live here
    ptd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (qb_empty),
        .q_item  (qb_item),
        .q_pop   (qb_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (res)
    );

    assign char_code     = res.char_code;
    assign char_position = res.char_position;
    assign end_of_string = res.end_of_string;

endmodule

// ===== verif/testbench.sv =====
// testbench for the packed five-bit text decoder: predictor, driver, monitor and checks
`timescale 1ns / 100ps

module testbench;
    import ptd_pkg::*;

    // bit 7 of the high byte closes the string
    localparam int END_BIT = 7;
    // idle chance per cycle, in percent, outside the calm window
    localparam int IDLE_PCT = 18;
    // window of cycles in which neither side idles
    localparam int CALM_FROM = 300;
    localparam int CALM_TO = 700;
    // worst case is far below this: ~300 words, 4 results each, random stalls
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 16;

    // one packed text word as it crosses the input port
    typedef struct packed {
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
    } text_word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [BYTE_W-1:0] low_byte = '0;
    logic [BYTE_W-1:0] high_byte = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  char_position;
    logic              end_of_string;

    packed_five_bit_text_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .low_byte      (low_byte),
        .high_byte     (high_byte),
        .empty         (empty),
        .pop           (pop),
        .char_code     (char_code),
        .char_position (char_position),
        .end_of_string (end_of_string)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // the two fixed alphabets, indexed by code
    string letter_set = " abcdefghijklmnopqrstuvwxyz?:'-";
    string digit_set = " 0123456789abcdefghilmnorstuwy-";

    text_word_t  pending_words[$];
    ptd_result_t expected_chars[$];
    text_word_t  next_word;

    // predictor state, mirrors the decoder after reset
    logic              alt_alphabet = 1'b0;
    logic [POS_W-1:0]  next_position = '0;

    int unsigned cyc = 0;
    int          errors = 0;
    int          words_sent = 0;
    int          chars_checked = 0;
    int          ends_checked = 0;
    int          position_wraps = 0;
    int          toggles_seen = 0;

    // both sides run flat out inside the calm window
    wire calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

    function automatic logic [CHAR_W-1:0] glyph(input logic alt,
                                                input logic [CODE_W-1:0] code);
        byte ch;
        if (alt)
        begin
            ch = digit_set[code];
        end
        else
        begin
            ch = letter_set[code];
        end
        return ch[CHAR_W-1:0];
    endfunction

    function automatic text_word_t pack_word(input logic [CODE_W-1:0] c0,
                                             input logic [CODE_W-1:0] c1,
                                             input logic [CODE_W-1:0] c2,
                                             input logic last);
        return {last, c2, c1, c0};
    endfunction

    // toggle code comes up more often than a uniform pick would give
    function automatic logic [CODE_W-1:0] pick_code();
        logic [CODE_W-1:0] c;
        if ($urandom_range(0, 9) == 0)
        begin
            c = TOGGLE_CODE;
        end
        else
        begin
            c = CODE_W'($urandom_range(0, 30));
        end
        return c;
    endfunction

    // expected characters for one accepted word, in output order
    task automatic decode_word(input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi);
        logic [CODE_W-1:0] codes [NUM_CODES];
        ptd_result_t       r;
        codes[0] = lo[4:0];
        codes[1] = {hi[1:0], lo[7:5]};
        codes[2] = hi[6:2];
        for (int i = 0; i < NUM_CODES; i++)
        begin
            if (codes[i] == TOGGLE_CODE)
            begin
                // flips the alphabet, emits nothing, position stays
                alt_alphabet = ~alt_alphabet;
                toggles_seen++;
            end
            else
            begin
                r = '{char_code: glyph(alt_alphabet, codes[i]),
                      char_position: next_position, end_of_string: 1'b0};
                expected_chars.push_back(r);
                if (next_position == '1)
                begin
                    position_wraps++;
                end
                next_position = next_position + 1'b1;
            end
        end
        if (hi[END_BIT])
        begin
            // terminator: char 0 at the current position, then position clears
            // alphabet is left alone and carries into the next string
            r = '{char_code: '0, char_position: next_position, end_of_string: 1'b1};
            expected_chars.push_back(r);
            next_position = '0;
        end
    endtask

    task automatic check_result();
        ptd_result_t exp_r;
        if (expected_chars.size() == 0)
        begin
            $display("%0t: result with nothing expected: char %0d pos %0d end %0b",
                     $time, char_code, char_position, end_of_string);
            errors++;
        end
        else
        begin
            exp_r = expected_chars.pop_front();
            if (char_code !== exp_r.char_code)
            begin
                $display("%0t: char_code expected %0d actual %0d (pos %0d)",
                         $time, exp_r.char_code, char_code, exp_r.char_position);
                errors++;
            end
            if (char_position !== exp_r.char_position)
            begin
                $display("%0t: char_position expected %0d actual %0d",
                         $time, exp_r.char_position, char_position);
                errors++;
            end
            if (end_of_string !== exp_r.end_of_string)
            begin
                $display("%0t: end_of_string expected %0b actual %0b (pos %0d)",
                         $time, exp_r.end_of_string, end_of_string, exp_r.char_position);
                errors++;
            end
            if (exp_r.end_of_string)
            begin
                ends_checked++;
            end
            else
            begin
                chars_checked++;
            end
        end
    endtask

    // driver: one transfer per edge with push high and full low
    // the predictor runs on the values that were on the ports at that edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                decode_word(low_byte, high_byte);
                words_sent++;
            end
            // hold the word while the decoder is full
            if (!push || !full)
            begin
                if (pending_words.size() > 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_word = pending_words.pop_front();
                    push      <= 1'b1;
                    low_byte  <= next_word.lo;
                    high_byte <= next_word.hi;
                end
                else
                begin
                    // junk on the data lines while idle
                    push      <= 1'b0;
                    low_byte  <= BYTE_W'($urandom);
                    high_byte <= BYTE_W'($urandom);
                end
            end
        end
    end

    // monitor: checks each result transfer, stalls pop at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                check_result();
            end
            pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // cycle counter and run timeout
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected, %0d words unsent",
                     $time, expected_chars.size(), pending_words.size());
            $display("FAIL packed_five_bit_text_decoder");
            $finish;
        end
    end

    initial
    begin
        int random_words;
        int str_len;
        // directed: three spaces, then codes 1..30 in the first alphabet
        pending_words.push_back(pack_word(5'd0, 5'd0, 5'd0, 1'b0));
        for (int c = 1; c <= 30; c += 3)
        begin
            pending_words.push_back(pack_word(CODE_W'(c), CODE_W'(c + 1), CODE_W'(c + 2), 1'b0));
        end
        // three toggles leave the second alphabet selected; terminator alone
        pending_words.push_back(pack_word(TOGGLE_CODE, TOGGLE_CODE, TOGGLE_CODE, 1'b1));
        // alphabet carries into the new string: codes 1..30 in the second alphabet
        for (int c = 1; c <= 30; c += 3)
        begin
            pending_words.push_back(pack_word(CODE_W'(c), CODE_W'(c + 1), CODE_W'(c + 2), 1'b0));
        end
        // all-zero end word, toggles around a character, all-ones word
        pending_words.push_back(pack_word(5'd0, 5'd0, 5'd0, 1'b1));
        pending_words.push_back(pack_word(TOGGLE_CODE, 5'd30, TOGGLE_CODE, 1'b0));
        pending_words.push_back(pack_word(5'd30, TOGGLE_CODE, 5'd30, 1'b1));
        pending_words.push_back(16'hFFFF);

        // random strings; the first is long enough to wrap the position
        random_words = 0;
        while (random_words < 255)
        begin
            str_len = (random_words == 0) ? 100 : $urandom_range(1, 8);
            for (int i = 0; i < str_len; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    // raw word, end mark random
                    pending_words.push_back(text_word_t'(16'($urandom)));
                end
                else
                begin
                    pending_words.push_back(pack_word(pick_code(), pick_code(), pick_code(),
                                                      i == str_len - 1));
                end
                random_words++;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // all words handed over, then all results back, then a short drain
        while (pending_words.size() > 0 || push)
        begin
            @(posedge clk);
        end
        while (expected_chars.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d words, %0d characters and %0d string ends checked",
                 words_sent, chars_checked, ends_checked);
        $display("%0d alphabet toggles, %0d position wraps, %0d mismatches",
                 toggles_seen, position_wraps, errors);
        if (errors == 0)
        begin
            $display("PASS packed_five_bit_text_decoder");
        end
        else
        begin
            $display("FAIL packed_five_bit_text_decoder");
        end
        $finish;
    end

endmodule

// ===== packed_five_bit_text_decoder.f =====
hdl/ptd_pkg.sv
hdl/ptd_front.sv
hdl/ptd_queue.sv
hdl/ptd_back.sv
hdl/packed_five_bit_text_decoder.sv
verif/testbench.sv
